/* rtl/bdq_pkg.sv */
// shared constants, codes and word types of the bounded deque
package bdq_pkg;

    // ring depth, kept a power of two so ring offsets wrap by truncation
    localparam int DEPTH = 16;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int CAP_W  = 5;
    localparam int FILL_W = 5;

    // input command codes
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [2:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [2:0] CMD_POP_REAR   = 3'd3;
    localparam logic [2:0] CMD_DUMP       = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // datapath operation codes
    localparam logic [3:0] OP_NONE       = 4'd0;
    localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
    localparam logic [3:0] OP_PUSH_REAR  = 4'd2;
    localparam logic [3:0] OP_POP_FRONT  = 4'd3;
    localparam logic [3:0] OP_POP_REAR   = 4'd4;
    localparam logic [3:0] OP_DUMP_READ  = 4'd5;
    localparam logic [3:0] OP_OVERFLOW   = 4'd6;
    localparam logic [3:0] OP_UNDERFLOW  = 4'd7;
    localparam logic [3:0] OP_EMPTY      = 4'd8;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] push_value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]          status;
        logic signed [31:0]  data_word;
        logic [FILL_W-1:0]   fill_count;
        logic                last;
    } out_word_t;

    typedef struct packed {
        logic [3:0]       op;
        logic [PTR_W-1:0] offset;
        logic             dump_last;
    } dp_cmd_t;

    typedef struct packed {
        logic             empty;
        logic             full;
        logic [CNT_W-1:0] count;
    } dp_status_t;

endpackage

/* rtl/bdq_ctrl.sv */
// command decode and dump sequencer of the bounded deque
module bdq_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [2:0]          command,
    input  bdq_pkg::dp_status_t dp_status,
    output bdq_pkg::dp_cmd_t    dp_cmd,
    output logic                busy
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic                      state_reg, state_next;
    logic [bdq_pkg::PTR_W-1:0] idx_reg, idx_next;
    logic                      accept;
    logic [bdq_pkg::CNT_W-1:0] count_m1;
    logic                      idx_is_last;

    assign busy        = (state_reg == S_DUMP);
    assign accept      = start && !busy;
    assign count_m1    = dp_status.count - bdq_pkg::CNT_W'(1);
    assign idx_is_last = (bdq_pkg::CNT_W'(idx_reg) == count_m1);

    always_comb
    begin
        state_next       = state_reg;
        idx_next         = idx_reg;
        dp_cmd.op        = bdq_pkg::OP_NONE;
        dp_cmd.offset    = '0;
        dp_cmd.dump_last = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (command)
                        bdq_pkg::CMD_PUSH_FRONT:
                            dp_cmd.op = dp_status.full ? bdq_pkg::OP_OVERFLOW
                                                       : bdq_pkg::OP_PUSH_FRONT;
                        bdq_pkg::CMD_PUSH_REAR:
                            dp_cmd.op = dp_status.full ? bdq_pkg::OP_OVERFLOW
                                                       : bdq_pkg::OP_PUSH_REAR;
                        bdq_pkg::CMD_POP_FRONT:
                            dp_cmd.op = dp_status.empty ? bdq_pkg::OP_UNDERFLOW
                                                        : bdq_pkg::OP_POP_FRONT;
                        bdq_pkg::CMD_POP_REAR:
                            dp_cmd.op = dp_status.empty ? bdq_pkg::OP_UNDERFLOW
                                                        : bdq_pkg::OP_POP_REAR;
                        bdq_pkg::CMD_DUMP:
                        begin
                            if (dp_status.empty)
                            begin
                                dp_cmd.op = bdq_pkg::OP_EMPTY;
                            end
                            else
                            begin
                                // first word read at accept, rest in dump state
                                dp_cmd.op        = bdq_pkg::OP_DUMP_READ;
                                dp_cmd.dump_last = (dp_status.count ==
                                                    bdq_pkg::CNT_W'(1));
                                if (!dp_cmd.dump_last)
                                begin
                                    state_next = S_DUMP;
                                    idx_next   = bdq_pkg::PTR_W'(1);
                                end
                            end
                        end
                        default:
                            dp_cmd.op = bdq_pkg::OP_NONE;
                    endcase
                end
            end
            S_DUMP:
            begin
                dp_cmd.op        = bdq_pkg::OP_DUMP_READ;
                dp_cmd.offset    = idx_reg;
                dp_cmd.dump_last = idx_is_last;
                idx_next         = idx_reg + bdq_pkg::PTR_W'(1);
                if (idx_is_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* rtl/bdq_dp.sv */
// ring storage, pointers, capacity register and result register of the deque
module bdq_dp (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bdq_pkg::dp_cmd_t           dp_cmd,
    input  logic signed [31:0]         push_value,
    input  logic                       cfg_we,
    input  logic [bdq_pkg::CAP_W-1:0]  cfg_wdata,
    output bdq_pkg::dp_status_t        dp_status,
    output bdq_pkg::out_word_t         rsp,
    output logic                       rsp_valid
);

    logic [31:0] mem [bdq_pkg::DEPTH];

    logic [bdq_pkg::PTR_W-1:0] fp_reg, fp_next;
    logic [bdq_pkg::CNT_W-1:0] count_reg, count_next;
    logic [bdq_pkg::CAP_W-1:0] capacity_reg;

    logic                      wr_en, rd_en;
    logic [bdq_pkg::PTR_W-1:0] wr_addr, rd_addr;
    logic [31:0]               rd_data_reg;

    logic                       valid_reg, valid_next;
    logic [1:0]                 status_reg, status_next;
    logic [bdq_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic                       last_reg, last_next;
    logic                       use_mem_reg, use_mem_next;

    logic [bdq_pkg::PTR_W-1:0] count_lo;

    assign count_lo        = count_reg[bdq_pkg::PTR_W-1:0];
    assign dp_status.count = count_reg;
    assign dp_status.empty = (count_reg == '0);
    // count >= min(capacity, depth)
    assign dp_status.full  = (32'(count_reg) >= 32'(capacity_reg)) ||
                             (count_reg == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));

    always_comb
    begin
        fp_next      = fp_reg;
        count_next   = count_reg;
        wr_en        = 1'b0;
        wr_addr      = fp_reg + count_lo;
        rd_en        = 1'b0;
        rd_addr      = fp_reg + dp_cmd.offset;
        valid_next   = 1'b1;
        status_next  = bdq_pkg::ST_OK;
        fill_next    = count_reg;
        last_next    = 1'b1;
        use_mem_next = 1'b0;
        unique case (dp_cmd.op)
            bdq_pkg::OP_PUSH_FRONT:
            begin
                fp_next    = fp_reg - bdq_pkg::PTR_W'(1);
                wr_en      = 1'b1;
                wr_addr    = fp_reg - bdq_pkg::PTR_W'(1);
                count_next = count_reg + bdq_pkg::CNT_W'(1);
                fill_next  = count_next;
            end
            bdq_pkg::OP_PUSH_REAR:
            begin
                wr_en      = 1'b1;
                count_next = count_reg + bdq_pkg::CNT_W'(1);
                fill_next  = count_next;
            end
            bdq_pkg::OP_POP_FRONT:
            begin
                rd_en        = 1'b1;
                rd_addr      = fp_reg;
                fp_next      = fp_reg + bdq_pkg::PTR_W'(1);
                count_next   = count_reg - bdq_pkg::CNT_W'(1);
                fill_next    = count_next;
                use_mem_next = 1'b1;
            end
            bdq_pkg::OP_POP_REAR:
            begin
                rd_en        = 1'b1;
                rd_addr      = fp_reg + count_lo - bdq_pkg::PTR_W'(1);
                count_next   = count_reg - bdq_pkg::CNT_W'(1);
                fill_next    = count_next;
                use_mem_next = 1'b1;
            end
            bdq_pkg::OP_DUMP_READ:
            begin
                rd_en        = 1'b1;
                last_next    = dp_cmd.dump_last;
                use_mem_next = 1'b1;
            end
            bdq_pkg::OP_OVERFLOW:
                status_next = bdq_pkg::ST_OVER;
            bdq_pkg::OP_UNDERFLOW:
                status_next = bdq_pkg::ST_UNDER;
            bdq_pkg::OP_EMPTY:
            begin
                status_next = bdq_pkg::ST_EMPTY;
                fill_next   = '0;
            end
            default:
                valid_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= push_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg       <= '0;
            count_reg    <= '0;
            capacity_reg <= bdq_pkg::CAP_W'(16);
            valid_reg    <= 1'b0;
        end
        else
        begin
            fp_reg    <= fp_next;
            count_reg <= count_next;
            valid_reg <= valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        fill_reg    <= fill_next;
        last_reg    <= last_next;
        use_mem_reg <= use_mem_next;
    end

    assign rsp_valid      = valid_reg;
    assign rsp.status     = status_reg;
    assign rsp.data_word  = use_mem_reg ? rd_data_reg : '0;
    assign rsp.fill_count = bdq_pkg::FILL_W'(fill_reg);
    assign rsp.last       = last_reg;

endmodule

/* rtl/bounded_deque.sv */
// top level of the bounded double-ended queue of signed 32-bit words
//
// usage
//   command channel: a word on cmd is taken at a rising edge with start high
//   and busy low. cmd.command selects push front, push rear, pop front,
//   pop rear or dump; cmd.push_value is the word inserted by a push.
//   result channel: each result word sits on rsp for exactly one cycle,
//   flagged by rsp_valid. the receiver cannot stall it and must take it.
//   config: cfg_we high writes cfg_wdata into the capacity register at the
//   edge; write it only while no command is in flight.
// timing
//   every valid command gives its first result in the cycle after it is taken. push and pop
//   run one word per cycle with busy low, since the ring is a single
//   registered-read memory that a pop reads at the accept edge.
//   a dump reads one ring slot a cycle: its results come on consecutive
//   cycles and busy stays high until the last slot has been read.
//   unused command codes are dropped without a result.
// reset
//   rst_n low empties the queue (count and front pointer to zero) and sets
//   capacity to 16; ring contents are left as they are.
module bounded_deque (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bdq_pkg::in_word_t         cmd,
    output logic                      rsp_valid,
    output bdq_pkg::out_word_t        rsp,
    input  logic                      cfg_we,
    input  logic [bdq_pkg::CAP_W-1:0] cfg_wdata
);

    // command and status between sequencer and datapath
    bdq_pkg::dp_cmd_t    dp_cmd;
    bdq_pkg::dp_status_t dp_status;

    // decodes commands against full and empty, steps through dumps
    bdq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (cmd.command),
        .dp_status (dp_status),
        .dp_cmd    (dp_cmd),
        .busy      (busy)
    );

    // ring memory, pointers, capacity and registered result
    bdq_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .push_value (cmd.push_value),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .dp_status  (dp_status),
        .rsp        (rsp),
        .rsp_valid  (rsp_valid)
    );

endmodule

/* sim/bounded_deque_tb.sv */
// self-checking testbench for the bounded double-ended queue
module bounded_deque_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // command codes the block drops without a result
    localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 2;
    // a result lands in the cycle after its word; the settle pause catches stray words
    localparam int SETTLE_CYCLES = 4;
    // longest quiet stretch of a correct run is a sender gap or a settle pause
    localparam int STALL_LIMIT   = 500;
    localparam int PHASE_WORDS   = 20;
    localparam int BURST_WORDS   = 20;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        start     = 1'b0;
    logic                        busy;
    bdq_pkg::in_word_t           cmd       = '0;
    logic                        rsp_valid;
    bdq_pkg::out_word_t          rsp;
    logic                        cfg_we    = 1'b0;
    logic [bdq_pkg::CAP_W-1:0]   cfg_wdata = '0;

    // shadow copy of the deque: ring, front pointer, fill and capacity
    logic signed [31:0]          ring_shadow [bdq_pkg::DEPTH];
    int                          front_idx;
    int                          held;
    logic [bdq_pkg::CAP_W-1:0]   capacity_shadow;

    // results still owed by the block, oldest first
    bdq_pkg::out_word_t          owed_results [$];

    int                          error_count;
    int                          quiet_cycles;
    int                          gap_max;

    always #CLK_HALF clk = ~clk;

    bounded_deque u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // ring slot at a given distance from the front
    function automatic logic [bdq_pkg::PTR_W-1:0] ring_pos(input int offset);
        return bdq_pkg::PTR_W'((front_idx + offset) % bdq_pkg::DEPTH);
    endfunction

    // ---------------------------------------------------------------
    // prediction: apply one accepted command word to the shadow deque
    // and queue the result words it must produce
    // ---------------------------------------------------------------
    function automatic void apply_command(input bdq_pkg::in_word_t w);
        bdq_pkg::out_word_t r;
        int                 limit;
        int                 k;
        r      = '0;
        r.last = 1'b1;
        // capacity above the ring size means a full ring
        limit  = (int'(capacity_shadow) > bdq_pkg::DEPTH) ? bdq_pkg::DEPTH
                                                          : int'(capacity_shadow);
        case (w.command)
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_REAR:
            begin
                if (held >= limit)
                begin
                    // overflow leaves everything as it was
                    r.status = bdq_pkg::ST_OVER;
                end
                else
                begin
                    if (w.command == bdq_pkg::CMD_PUSH_FRONT)
                    begin
                        front_idx              = int'(ring_pos(bdq_pkg::DEPTH - 1));
                        ring_shadow[ring_pos(0)] = w.push_value;
                    end
                    else
                    begin
                        ring_shadow[ring_pos(held)] = w.push_value;
                    end
                    held++;
                    r.status = bdq_pkg::ST_OK;
                end
                r.fill_count = bdq_pkg::FILL_W'(held);
                owed_results.push_back(r);
            end
            bdq_pkg::CMD_POP_FRONT, bdq_pkg::CMD_POP_REAR:
            begin
                if (held == 0)
                begin
                    r.status = bdq_pkg::ST_UNDER;
                end
                else
                begin
                    if (w.command == bdq_pkg::CMD_POP_FRONT)
                    begin
                        r.data_word = ring_shadow[ring_pos(0)];
                        front_idx   = int'(ring_pos(1));
                    end
                    else
                    begin
                        r.data_word = ring_shadow[ring_pos(held - 1)];
                    end
                    held--;
                    r.status = bdq_pkg::ST_OK;
                end
                r.fill_count = bdq_pkg::FILL_W'(held);
                owed_results.push_back(r);
            end
            bdq_pkg::CMD_DUMP:
            begin
                if (held == 0)
                begin
                    r.status = bdq_pkg::ST_EMPTY;
                    owed_results.push_back(r);
                end
                else
                begin
                    // one word per element, front to rear, last one flagged
                    for (k = 0; k < held; k++)
                    begin
                        r.status     = bdq_pkg::ST_OK;
                        r.data_word  = ring_shadow[ring_pos(k)];
                        r.fill_count = bdq_pkg::FILL_W'(held);
                        r.last       = (k == held - 1);
                        owed_results.push_back(r);
                    end
                end
            end
            default:
            begin
                // spare codes: no result, no state change
            end
        endcase
    endfunction

    // push values lean on the sign boundaries now and then
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return 32'sh0000_0000;
            3:       return 32'shffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // random command word; push_pct steers the deque toward full or empty
    function automatic bdq_pkg::in_word_t random_word(input int push_pct);
        bdq_pkg::in_word_t w;
        int                roll;
        roll         = $urandom_range(0, 99);
        w.push_value = pick_value();
        if (roll < 5)
            w.command = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
        else if (roll < 13)
            w.command = bdq_pkg::CMD_DUMP;
        else if ($urandom_range(0, 99) < push_pct)
            w.command = $urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_FRONT
                                             : bdq_pkg::CMD_PUSH_REAR;
        else
            w.command = $urandom_range(0, 1) ? bdq_pkg::CMD_POP_FRONT
                                             : bdq_pkg::CMD_POP_REAR;
        return w;
    endfunction

    // ---------------------------------------------------------------
    // sender: optional gap, then hold start until the word is taken.
    // start stays high across back-to-back words so it is never lowered
    // and raised in one time step
    // ---------------------------------------------------------------
    task automatic send_word(input bdq_pkg::in_word_t w);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= w;
        // busy read here is the value the block saw at this edge
        do
            @(posedge clk);
        while (busy !== 1'b0);
        apply_command(w);
    endtask

    // sender holds off until every owed result is back, then settles
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (owed_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // capacity writes only happen with the block idle
    task automatic write_capacity(input logic [bdq_pkg::CAP_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we          <= 1'b0;
        capacity_shadow  = value;
    endtask

    // ---------------------------------------------------------------
    // result checker: every strobed word is compared with the oldest owed one
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid === 1'b1)
        begin
            if (owed_results.size() == 0)
            begin
                $error("unexpected result word: status %0d data_word %0d %s %0d last %0d",
                       rsp.status, rsp.data_word, "fill_count", rsp.fill_count, rsp.last);
                error_count++;
            end
            else
            begin
                if (rsp.status !== owed_results[0].status)
                begin
                    $error("status: expected %0d, got %0d", owed_results[0].status, rsp.status);
                    error_count++;
                end
                if (rsp.data_word !== owed_results[0].data_word)
                begin
                    $error("data_word: expected %0d, got %0d",
                           owed_results[0].data_word, rsp.data_word);
                    error_count++;
                end
                if (rsp.fill_count !== owed_results[0].fill_count)
                begin
                    $error("fill_count: expected %0d, got %0d",
                           owed_results[0].fill_count, rsp.fill_count);
                    error_count++;
                end
                if (rsp.last !== owed_results[0].last)
                begin
                    $error("last: expected %0d, got %0d", owed_results[0].last, rsp.last);
                    error_count++;
                end
                void'(owed_results.pop_front());
            end
        end
    end

    // watchdog: counts cycles where no word moves on any port
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || rsp_valid === 1'b1 || cfg_we || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("bounded_deque_tb failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // test cases
    // ---------------------------------------------------------------

    // fresh deque: empty dump and underflow on both ends
    task automatic test_empty_deque();
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_DUMP, 32'sd0});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_POP_FRONT, 32'sd0});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_POP_REAR, 32'sd0});
    endtask

    // every command with extreme values, spare codes in between
    task automatic test_basic_commands();
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_REAR, 32'sh7fff_ffff});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_FRONT, 32'sh8000_0000});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_REAR, 32'sh0000_0000});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_FRONT, 32'shffff_ffff});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_DUMP, 32'sh5555_aaaa});
        send_word(bdq_pkg::in_word_t'{CMD_SPARE_FIRST, 32'sh1234_5678});
        send_word(bdq_pkg::in_word_t'{CMD_SPARE_FIRST + 3'd1, 32'shffff_ffff});
        send_word(bdq_pkg::in_word_t'{CMD_SPARE_LAST, 32'sh8000_0000});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_POP_REAR, 32'sd0});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_POP_FRONT, 32'sd0});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_DUMP, 32'sd0});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_POP_FRONT, 32'sd0});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_POP_REAR, 32'sd0});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_POP_REAR, 32'sd0});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_DUMP, 32'sd0});
    endtask

    // smallest capacities, and a capacity dropped below the fill level
    task automatic test_capacity_edges();
        write_capacity(bdq_pkg::CAP_W'(1));
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_FRONT, 32'sh0bad_cafe});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_REAR, 32'sh0000_0001});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_FRONT, 32'sh0000_0002});
        write_capacity(bdq_pkg::CAP_W'(0));
        // held word stays, every push overflows
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_REAR, 32'sh0000_0003});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_POP_REAR, 32'sd0});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_FRONT, 32'sh0000_0004});
        write_capacity(bdq_pkg::CAP_W'(3));
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_REAR, 32'sh0000_0005});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_REAR, 32'sh0000_0006});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_FRONT, 32'sh0000_0007});
        write_capacity(bdq_pkg::CAP_W'(1));
        // three held, capacity one: overflow until pops bring it under
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_FRONT, 32'sh0000_0008});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_POP_FRONT, 32'sd0});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_POP_FRONT, 32'sd0});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_POP_FRONT, 32'sd0});
        send_word(bdq_pkg::in_word_t'{bdq_pkg::CMD_PUSH_REAR, 32'sh0000_0009});
    endtask

    // random phases over a spread of capacities; each phase fills then drains,
    // with a pause mid-phase until every owed word is back
    task automatic test_random_traffic();
        logic [bdq_pkg::CAP_W-1:0] caps [6];
        bdq_pkg::in_word_t         w;
        int                        p;
        int                        n;
        caps = '{bdq_pkg::CAP_W'(31), bdq_pkg::CAP_W'(16), bdq_pkg::CAP_W'(2),
                 bdq_pkg::CAP_W'(9), bdq_pkg::CAP_W'(0),
                 bdq_pkg::CAP_W'($urandom_range(1, 16))};
        gap_max = 11;
        for (p = 0; p < 6; p++)
        begin
            write_capacity(caps[p]);
            n = 0;
            while (n < PHASE_WORDS)
            begin
                w = random_word((n < PHASE_WORDS / 2) ? 80 : 25);
                send_word(w);
                if (w.command <= bdq_pkg::CMD_DUMP)
                    n++;
                if (n == PHASE_WORDS / 2)
                    wait_drained();
            end
        end
    endtask

    // no sender gaps at all, capacity set to the full ring, dumps mixed in
    task automatic test_back_to_back();
        bdq_pkg::in_word_t w;
        int                n;
        write_capacity(bdq_pkg::CAP_W'(16));
        gap_max = 0;
        n = 0;
        while (n < BURST_WORDS)
        begin
            w = random_word(60);
            send_word(w);
            if (w.command <= bdq_pkg::CMD_DUMP)
                n++;
        end
        gap_max = 11;
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        error_count     = 0;
        quiet_cycles    = 0;
        gap_max         = 3;
        front_idx       = 0;
        held            = 0;
        capacity_shadow = bdq_pkg::CAP_W'(16);
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_deque();
        test_basic_commands();
        test_capacity_edges();
        test_random_traffic();
        test_back_to_back();

        // all owed words back, then a settle pause to catch anything extra
        wait_drained();
        if (error_count == 0)
            $display("bounded_deque_tb passed");
        else
            $display("bounded_deque_tb failed");
        $finish;
    end

endmodule

/* files.f */
rtl/bdq_pkg.sv
rtl/bdq_ctrl.sv
rtl/bdq_dp.sv
rtl/bounded_deque.sv
sim/bounded_deque_tb.sv
